/* sv/icf_pkg.sv */
package icf_pkg;

    localparam int unsigned ADDR_W  = 25;
    localparam int unsigned LIMIT_W = 26;
    localparam int unsigned CFG_W   = 26;

    localparam logic [ADDR_W-1:0]  EXT_START_RST   = 25'd131072;
    localparam logic [LIMIT_W-1:0] FLASH_LIMIT_RST = 26'd262144;

    // register index on the config port
    localparam logic CFG_EXT_START   = 1'b0;
    localparam logic CFG_FLASH_LIMIT = 1'b1;

    // request codes; 6 and 7 are unused
    typedef enum logic [2:0] {
        FUNC_CONNECT     = 3'd0,
        FUNC_READ_FLASH  = 3'd1,
        FUNC_LOAD_BYTE   = 3'd2,
        FUNC_WRITE_PAGE  = 3'd3,
        FUNC_READ_EEPROM = 3'd4,
        FUNC_WRITE_EEPROM = 3'd5
    } func_t;

    // serial programming opcodes
    localparam logic [7:0] OP_LOAD_EXT     = 8'h4D;
    localparam logic [7:0] OP_READ_FLASH   = 8'h20;
    localparam logic [7:0] OP_LOAD_BYTE    = 8'h40;
    localparam logic [7:0] OP_WRITE_PAGE   = 8'h4C;
    localparam logic [7:0] OP_READ_EEPROM  = 8'hA0;
    localparam logic [7:0] OP_WRITE_EEPROM = 8'hC0;
    localparam logic [7:0] EXT_NONE        = 8'hFF;
    localparam int unsigned EXT_SHIFT      = 17;

    // frame slots 0..3 hold the extended address frame, 4..7 the command
    localparam logic [2:0] SLOT_FIRST_EXT = 3'd0;
    localparam logic [2:0] SLOT_FIRST_CMD = 3'd4;
    localparam logic [2:0] SLOT_LAST      = 3'd7;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic            has_ext;
        logic            cap;     // final byte's reply is read data
    } frame_t;

endpackage

/* sv/icf_decode.sv */
module icf_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [2:0]                    func,
    input  logic [icf_pkg::ADDR_W-1:0]    address,
    input  logic [7:0]                    data,
    input  logic [icf_pkg::ADDR_W-1:0]    ext_start,
    input  logic [icf_pkg::LIMIT_W-1:0]   flash_limit,
    output icf_pkg::frame_t               frame,
    output logic                          frame_vld
);
    import icf_pkg::*;

    logic [7:0] ext_byte_reg;
    logic [7:0] ext_byte_next;
    logic [7:0] hh;
    logic       in_region;
    logic       need_ext;
    logic [7:0] odd;
    logic       is_flash;

    assign hh        = address[EXT_SHIFT +: 8];
    assign in_region = (address >= ext_start) &&
                       ({{(LIMIT_W-ADDR_W){1'b0}}, address} < flash_limit);
    assign need_ext  = in_region && (hh != ext_byte_reg);
    assign odd       = {4'd0, address[0], 3'd0};

    always_comb begin
        frame         = '0;
        frame_vld     = 1'b0;
        is_flash      = 1'b0;
        ext_byte_next = ext_byte_reg;
        frame.bytes[0] = OP_LOAD_EXT;
        frame.bytes[1] = 8'h00;
        frame.bytes[2] = hh;
        frame.bytes[3] = 8'h00;
        frame.bytes[5] = address[16:9];
        frame.bytes[6] = address[8:1];
        unique case (func_t'(func))
            FUNC_CONNECT: begin
                ext_byte_next = EXT_NONE;
            end
            FUNC_READ_FLASH: begin
                is_flash       = 1'b1;
                frame.bytes[4] = OP_READ_FLASH | odd;
                frame.cap      = 1'b1;
            end
            FUNC_LOAD_BYTE: begin
                is_flash       = 1'b1;
                frame.bytes[4] = OP_LOAD_BYTE | odd;
                frame.bytes[7] = data;
            end
            FUNC_WRITE_PAGE: begin
                is_flash       = 1'b1;
                frame.bytes[4] = OP_WRITE_PAGE;
            end
            FUNC_READ_EEPROM: begin
                frame_vld      = 1'b1;
                frame.bytes[4] = OP_READ_EEPROM;
                frame.bytes[5] = address[15:8];
                frame.bytes[6] = address[7:0];
                frame.cap      = 1'b1;
            end
            FUNC_WRITE_EEPROM: begin
                frame_vld      = 1'b1;
                frame.bytes[4] = OP_WRITE_EEPROM;
                frame.bytes[5] = address[15:8];
                frame.bytes[6] = address[7:0];
                frame.bytes[7] = data;
            end
            default: begin
            end
        endcase
        if (is_flash) begin
            frame_vld     = 1'b1;
            frame.has_ext = need_ext;
            if (need_ext) begin
                ext_byte_next = hh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_byte_reg <= EXT_NONE;
        end else if (accept) begin
            ext_byte_reg <= ext_byte_next;
        end
    end

endmodule

/* sv/icf_serializer.sv */
module icf_serializer (
    input  logic            aclk,
    input  logic            aresetn,
    input  icf_pkg::frame_t frame_in,
    input  logic            load,
    output logic            ready,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_tx_byte,
    output logic            m_capture_reply,
    output logic            m_last
);
    import icf_pkg::*;

    frame_t     frame_reg, frame_next;
    logic       frame_vld_reg, frame_vld_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] tx_reg, tx_next;
    logic       cap_reg, cap_next;
    logic       last_reg, last_next;
    logic       emit;
    logic       fin;

    assign emit  = frame_vld_reg && (!out_vld_reg || m_ready);
    assign fin   = emit && (idx_reg == SLOT_LAST);
    assign ready = !frame_vld_reg || fin;

    always_comb begin
        frame_next     = frame_reg;
        frame_vld_next = frame_vld_reg;
        idx_next       = idx_reg;
        out_vld_next   = out_vld_reg;
        tx_next        = tx_reg;
        cap_next       = cap_reg;
        last_next      = last_reg;
        if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (emit) begin
            out_vld_next = 1'b1;
            tx_next      = frame_reg.bytes[idx_reg];
            cap_next     = frame_reg.cap && fin;
            last_next    = fin;
            idx_next     = 3'(idx_reg + 3'd1);
            if (fin) begin
                frame_vld_next = 1'b0;
            end
        end
        if (load) begin
            frame_next     = frame_in;
            frame_vld_next = 1'b1;
            idx_next       = frame_in.has_ext ? SLOT_FIRST_EXT : SLOT_FIRST_CMD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_vld_reg <= 1'b0;
            idx_reg       <= SLOT_FIRST_CMD;
            out_vld_reg   <= 1'b0;
        end else begin
            frame_vld_reg <= frame_vld_next;
            idx_reg       <= idx_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        tx_reg    <= tx_next;
        cap_reg   <= cap_next;
        last_reg  <= last_next;
    end

    assign m_valid         = out_vld_reg;
    assign m_tx_byte       = tx_reg;
    assign m_capture_reply = cap_reg;
    assign m_last          = last_reg;

endmodule

/* sv/isp_command_framer.sv */
// A request's bytes pass the frame register, then the byte output register.
// One output byte per cycle while m_ready is high; a request occupies the frame
//   register for its four command bytes (eight with an extended address frame).
// A new request is taken in the cycle its predecessor's last byte is emitted.
// Reset (aresetn, sync, active low): config to defaults, extended byte to FF.
module isp_command_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_func,
    input  logic [icf_pkg::ADDR_W-1:0]    s_address,
    input  logic [7:0]                    s_data,
    // byte channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_tx_byte,
    output logic                          m_capture_reply,
    output logic                          m_last,
    // config write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [icf_pkg::CFG_W-1:0]     cfg_data
);
    import icf_pkg::*;

    logic [ADDR_W-1:0]  ext_start_reg;
    logic [LIMIT_W-1:0] flash_limit_reg;
    logic               s_xfer;
    frame_t             frame;
    logic               frame_vld;

    // config registers; to be written only while idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_start_reg   <= EXT_START_RST;
            flash_limit_reg <= FLASH_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXT_START:   ext_start_reg   <= cfg_data[ADDR_W-1:0];
                CFG_FLASH_LIMIT: flash_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_xfer = s_valid && s_ready;

    // Decode: builds the whole frame and tracks the extended address byte.
    // Connect and unused codes produce no frame; they complete on transfer.
    icf_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_xfer),
        .func        (s_func),
        .address     (s_address),
        .data        (s_data),
        .ext_start   (ext_start_reg),
        .flash_limit (flash_limit_reg),
        .frame       (frame),
        .frame_vld   (frame_vld)
    );

    // Serializer: frame register feeding a byte output register.
    icf_serializer u_serializer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame_in        (frame),
        .load            (s_xfer && frame_vld),
        .ready           (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_capture_reply (m_capture_reply),
        .m_last          (m_last)
    );

endmodule

/* dv/isp_command_framer_tb.sv */
module isp_command_framer_tb;
    import icf_pkg::*;

    // Spare request codes: the block must swallow these without a frame.
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int unsigned BLOCK_SPAN = 32'h20000;   // one extended-address block
    localparam int unsigned ADDR_TOP   = 32'h1FFFFFF;
    localparam int unsigned LIMIT_TOP  = 32'h2000000;
    localparam int          SETTLE_CYCLES = 8;        // one full frame with extension

    // One byte of the serial stream, as it leaves the byte channel.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       capture_reply;
        logic       last;
    } spi_byte_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [2:0]          s_func    = '0;
    logic [ADDR_W-1:0]   s_address = '0;
    logic [7:0]          s_data    = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_tx_byte;
    logic                m_capture_reply;
    logic                m_last;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_EXT_START;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Local copy of the framer's registers and extended-address byte.
    logic [ADDR_W-1:0]   ext_start   = EXT_START_RST;
    logic [LIMIT_W-1:0]  flash_limit = FLASH_LIMIT_RST;
    logic [7:0]          ext_byte    = EXT_NONE;

    spi_byte_t           frame_bytes[$];   // bytes still owed by the block, in order
    int                  mismatch_count = 0;
    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  hold_request   = 0;
    int                  hold_left      = 0;
    logic [ADDR_W-1:0]   prev_address   = '0;

    isp_command_framer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_address       (s_address),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_capture_reply (m_capture_reply),
        .m_last          (m_last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block wedges.
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic cap, input logic fin);
        spi_byte_t entry;
        entry.tx_byte       = b;
        entry.capture_reply = cap;
        entry.last          = fin;
        frame_bytes.push_back(entry);
    endfunction

    // Works out the serial bytes one request produces and updates the
    // extended-address byte the same way the block does.
    function automatic void build_frame(input logic [2:0] f, input logic [ADDR_W-1:0] a,
                                        input logic [7:0] d);
        logic [7:0] hh;
        logic [7:0] odd_bit;
        logic [7:0] opcode;
        hh      = 8'(a >> EXT_SHIFT);
        odd_bit = {4'b0000, a[0], 3'b000};
        case (f)
            FUNC_CONNECT: begin
                ext_byte = EXT_NONE;
            end
            FUNC_READ_FLASH, FUNC_LOAD_BYTE, FUNC_WRITE_PAGE: begin
                // Extension only inside [start, limit) and only when hh moved.
                // An hh of FF matches the reset mark, so no extension frame goes out then.
                if (a >= ext_start && a < flash_limit && hh != ext_byte) begin
                    ext_byte = hh;
                    push_byte(OP_LOAD_EXT, 1'b0, 1'b0);
                    push_byte(8'h00, 1'b0, 1'b0);
                    push_byte(hh, 1'b0, 1'b0);
                    push_byte(8'h00, 1'b0, 1'b0);
                end
                if (f == FUNC_READ_FLASH)     opcode = OP_READ_FLASH | odd_bit;
                else if (f == FUNC_LOAD_BYTE) opcode = OP_LOAD_BYTE | odd_bit;
                else                          opcode = OP_WRITE_PAGE;
                push_byte(opcode, 1'b0, 1'b0);
                push_byte(8'(a >> 9), 1'b0, 1'b0);
                push_byte(8'(a >> 1), 1'b0, 1'b0);
                push_byte((f == FUNC_LOAD_BYTE) ? d : 8'h00, f == FUNC_READ_FLASH, 1'b1);
            end
            FUNC_READ_EEPROM, FUNC_WRITE_EEPROM: begin
                push_byte((f == FUNC_READ_EEPROM) ? OP_READ_EEPROM : OP_WRITE_EEPROM,
                          1'b0, 1'b0);
                push_byte(a[15:8], 1'b0, 1'b0);
                push_byte(a[7:0], 1'b0, 1'b0);
                push_byte((f == FUNC_WRITE_EEPROM) ? d : 8'h00, f == FUNC_READ_EEPROM, 1'b1);
            end
            default: ;   // spare codes: no bytes, no state change
        endcase
    endfunction

    // Byte sink. A pending hold request forces a long stall so requests
    // back up into the framer; otherwise ready drops at the phase rate.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Every byte transfer is matched against the oldest owed byte.
    always @(posedge aclk) begin : byte_check
        spi_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h cap %0b last %0b",
                                     m_tx_byte, m_capture_reply, m_last));
            end else begin
                want = frame_bytes.pop_front();
                if (m_tx_byte !== want.tx_byte || m_capture_reply !== want.capture_reply ||
                    m_last !== want.last)
                    flag_error($sformatf("byte exp %02h/%0b/%0b got %02h/%0b/%0b",
                                         want.tx_byte, want.capture_reply, want.last,
                                         m_tx_byte, m_capture_reply, m_last));
            end
        end
    end

    // Offers one request and returns at the edge where it transfers.
    // Valid stays high on return so back-to-back requests need no gap;
    // whoever idles next lowers it.
    task automatic send_request(input logic [2:0] f, input logic [ADDR_W-1:0] a,
                                input logic [7:0] d);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid   <= 1'b1;
        s_func    <= f;
        s_address <= a;
        s_data    <= d;
        do @(posedge aclk); while (!s_ready);
        build_frame(f, a, d);
    endtask

    // Idles the request side, waits for every owed byte, then lets a
    // frame's worth of cycles pass for requests that emit nothing.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (frame_bytes.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (frame_bytes.size() != 0) begin
            flag_error($sformatf("%0d bytes never arrived", frame_bytes.size()));
            frame_bytes.delete();
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_EXT_START) ext_start   = value[ADDR_W-1:0];
        else                      flash_limit = value[LIMIT_W-1:0];
    endtask

    // Address mix: anywhere, inside the region, same 128K block as the last one
    // (extension suppressed while the stored byte is that block's), or right on a region edge.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int unsigned       span;
        span = (flash_limit > ext_start) ? int'(flash_limit - ext_start) : 0;
        case ($urandom_range(3))
            0: a = ADDR_W'($urandom);
            1: a = (span != 0) ? ADDR_W'(ext_start + ($urandom % span)) : ADDR_W'($urandom);
            2: a = {prev_address[ADDR_W-1:EXT_SHIFT], 17'($urandom)};
            default: begin
                case ($urandom_range(2))
                    0:       a = ext_start;
                    1:       a = ADDR_W'(flash_limit - 1);
                    default: a = ext_start - 1'b1;
                endcase
            end
        endcase
        prev_address = a;
        return a;
    endfunction

    function automatic logic [2:0] pick_func();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)       return FUNC_CONNECT;
        else if (r < 28) return FUNC_READ_FLASH;
        else if (r < 50) return FUNC_LOAD_BYTE;
        else if (r < 62) return FUNC_WRITE_PAGE;
        else if (r < 78) return FUNC_READ_EEPROM;
        else if (r < 94) return FUNC_WRITE_EEPROM;
        else if (r < 97) return FUNC_SPARE_6;
        else             return FUNC_SPARE_7;
    endfunction

    task automatic random_request();
        logic [2:0]        f;
        logic [ADDR_W-1:0] a;
        f = pick_func();
        a = pick_address();
        send_request(f, a, 8'($urandom));
    endtask

    task automatic random_config();
        int unsigned lo;
        int unsigned hi;
        case ($urandom_range(2))
            0: begin
                lo = BLOCK_SPAN * $urandom_range(0, 15);
                hi = lo + BLOCK_SPAN * $urandom_range(1, 16);
            end
            1: begin
                lo = $urandom_range(0, ADDR_TOP);
                hi = $urandom_range(0, LIMIT_TOP);
            end
            default: begin
                lo = 0;
                hi = LIMIT_TOP;
            end
        endcase
        write_reg(CFG_EXT_START, CFG_W'(lo));
        write_reg(CFG_FLASH_LIMIT, CFG_W'(hi));
    endtask

    // Reset-default region [128K, 256K): every request kind, edges of the
    // region, eeprom ignoring high address bits, connect, spare codes.
    task automatic test_directed_defaults();
        send_request(FUNC_READ_FLASH, 25'h0000000, 8'hFF);   // below region, data ignored
        send_request(FUNC_READ_FLASH, 25'h0020001, 8'h00);   // odd byte, first extension
        send_request(FUNC_LOAD_BYTE, 25'h0020001, 8'hFF);    // same block: no extension
        send_request(FUNC_WRITE_PAGE, 25'h003FFFF, 8'hA5);
        send_request(FUNC_READ_FLASH, 25'h0040000, 8'h00);   // at the limit: no extension
        send_request(FUNC_READ_EEPROM, 25'h1FFFFFF, 8'hFF);
        send_request(FUNC_WRITE_EEPROM, 25'h0000000, 8'h00);
        send_request(FUNC_WRITE_EEPROM, 25'h000FFFF, 8'hFF);
        send_request(FUNC_CONNECT, 25'h1FFFFFF, 8'hFF);      // stored byte back to FF
        send_request(FUNC_LOAD_BYTE, 25'h0020000, 8'h5A);    // extension again
        send_request(FUNC_SPARE_6, 25'h0020000, 8'h33);
        send_request(FUNC_SPARE_7, 25'h1FFFFFF, 8'hCC);
        wait_drained();
    endtask

    // Whole address space in the region; exercises the FF block that
    // matches the not-yet-sent mark.
    task automatic test_full_region();
        write_reg(CFG_EXT_START, '0);
        write_reg(CFG_FLASH_LIMIT, CFG_W'(LIMIT_TOP));
        send_request(FUNC_CONNECT, 25'h0000000, 8'h00);
        send_request(FUNC_READ_FLASH, 25'h1FE0000, 8'h00);   // hh FF: nothing extra
        send_request(FUNC_LOAD_BYTE, 25'h1FFFFFF, 8'hFF);
        send_request(FUNC_READ_FLASH, 25'h0000000, 8'h00);   // hh 00 goes out
        send_request(FUNC_READ_FLASH, 25'h1FE0000, 8'h00);   // now FF is a change
        wait_drained();
    endtask

    // Start at or above the limit: the extended frame never goes out.
    task automatic test_empty_region();
        write_reg(CFG_EXT_START, CFG_W'(ADDR_TOP));
        write_reg(CFG_FLASH_LIMIT, '0);
        send_request(FUNC_READ_FLASH, 25'h1FFFFFF, 8'h00);
        send_request(FUNC_LOAD_BYTE, 25'h0000000, 8'h81);
        write_reg(CFG_EXT_START, CFG_W'(32'h100000));
        write_reg(CFG_FLASH_LIMIT, CFG_W'(32'h100000));
        send_request(FUNC_WRITE_PAGE, 25'h0100000, 8'h00);
        wait_drained();
    endtask

    // Sink goes quiet for a long stretch while requests keep coming, so
    // the framer fills and must hold off the request side.
    task automatic test_backpressure();
        write_reg(CFG_EXT_START, '0);
        write_reg(CFG_FLASH_LIMIT, CFG_W'(32'h400000));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 300;
        repeat (24) random_request();
        wait_drained();
    endtask

    // Random traffic over the idling phases, new register settings each
    // phase. Page bursts (loads then a page write) are mixed with single
    // requests.
    task automatic test_random_traffic();
        int          src_pct[4]  = '{0, 65, 0, 7};
        int          sink_pct[4] = '{0, 0, 65, 7};
        int          sent;
        int          burst_len;
        logic [ADDR_W-1:0] base;
        for (int p = 0; p < 4; p++) begin
            random_config();
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            sent = 0;
            while (sent < 84) begin
                if ($urandom_range(99) < 25) begin
                    base      = pick_address();
                    burst_len = $urandom_range(2, 6);
                    for (int i = 0; i < burst_len; i++)
                        send_request(FUNC_LOAD_BYTE, base + ADDR_W'(i), 8'($urandom));
                    send_request(FUNC_WRITE_PAGE, base, 8'($urandom));
                    sent += burst_len + 1;
                end else begin
                    random_request();
                    sent++;
                end
            end
            wait_drained();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_full_region();
        test_empty_region();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* isp_command_framer.f */
sv/icf_pkg.sv
sv/icf_decode.sv
sv/icf_serializer.sv
sv/isp_command_framer.sv
dv/isp_command_framer_tb.sv
